// ----- hdl/i2cm_pkg.sv -----
// i2cm_pkg: types, codes and constants shared by the I2C master sequencer.
// No dependencies; compile first.
package i2cm_pkg;

    localparam int TIMER_BITS = 16;
    localparam int BYTE_BITS  = 8;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int BIT_CNT_W  = 4;
    localparam int CMD_W      = 3;

    localparam logic [CFG_BITS-1:0] HALF_BIT_RST  = 16'd4;
    localparam logic [CFG_BITS-1:0] STOP_PRE_RST  = 16'd1000;
    localparam logic [CFG_BITS-1:0] STOP_POST_RST = 16'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_BIT  = 2'd0,
        REG_STOP_PRE  = 2'd1,
        REG_STOP_POST = 2'd2
    } t_reg_idx;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_START   = 3'd1,
        CMD_RESTART = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_WRITE   = 3'd4,
        CMD_READ    = 3'd5,
        CMD_PARK    = 3'd6
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_DLY,
        PH_RS_REL,
        PH_RS_STR,
        PH_RS_DLY,
        PH_SP_PRE,
        PH_SP_DLY1,
        PH_SP_STR,
        PH_SP_DLY2,
        PH_SP_POST,
        PH_BIT_SETUP,
        PH_BIT_STR,
        PH_BIT_HOLD
    } t_phase;

endpackage

// ----- hdl/i2cm_cmd_if.sv -----
// i2cm_cmd_if: command/tick channel of the I2C master sequencer.
// Depends on i2cm_pkg for field widths.
interface i2cm_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [i2cm_pkg::CMD_W-1:0]      cmd;
    logic [i2cm_pkg::BYTE_BITS-1:0]  wr_data;
    logic                            send_ack;
    logic                            scl_in;
    logic                            sda_in;

    modport source (output valid, cmd, wr_data, send_ack, scl_in, sda_in, input ready);
    modport sink   (input valid, cmd, wr_data, send_ack, scl_in, sda_in, output ready);
endinterface

// ----- hdl/i2cm_res_if.sv -----
// i2cm_res_if: result channel of the I2C master sequencer.
// Depends on i2cm_pkg for field widths.
interface i2cm_res_if;
    logic                            valid;
    logic                            ready;
    logic                            scl_low;
    logic                            sda_low;
    logic                            busy_res;
    logic                            done_res;
    logic [i2cm_pkg::BYTE_BITS-1:0]  rd_data;
    logic                            ack_seen;
    logic                            rejected;

    modport source (output valid, scl_low, sda_low, busy_res, done_res, rd_data, ack_seen,
                     rejected, input ready);
    modport sink   (input valid, scl_low, sda_low, busy_res, done_res, rd_data, ack_seen,
                     rejected, output ready);
endinterface

// ----- hdl/i2c_master_sequencer_unit.sv -----
// i2c_master_sequencer_unit: tick-driven open-drain I2C master, top level.
// Depends on i2cm_pkg, i2cm_cmd_if and i2cm_res_if.
//
//  channel   | dir | beat contents
//  ----------+-----+----------------------------------------------------------
//  i_cmd     | in  | cmd, wr_data, send_ack, scl_in, sda_in (tick or command)
//  o_res     | out | scl_low, sda_low, busy_res, done_res, rd_data, ack_seen,
//            |     | rejected (one beat for every accepted input beat)
//  i_cfg_*   | in  | register write: half_bit_ticks, stop_pre_ticks,
//            |     | stop_post_ticks
//
// Each input beat updates the sequencer state and the result register at the
// same edge, so one beat per clock is sustained while o_res.ready stays high.
// The single result register sets the rate; it refills on the edge it drains.
// A stalled result holds i_cmd.ready low until the sink takes the beat.
// Synchronous active-low reset returns the sequencer to idle, lines released,
// and the timing registers to their defaults.
module i2c_master_sequencer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [i2cm_pkg::CFG_BITS-1:0]   i_cfg_data,
    i2cm_cmd_if.sink                        i_cmd,
    i2cm_res_if.source                      o_res
);
    import i2cm_pkg::*;

    // Timing registers
    logic [CFG_BITS-1:0]   r_half, r_stop_pre, r_stop_post;

    // Sequencer state
    t_phase                r_phase, n_phase;
    logic [CMD_W-1:0]      r_active, n_active;
    logic [BIT_CNT_W-1:0]  r_bit_count, n_bit_count;
    logic [BYTE_BITS-1:0]  r_shift, n_shift;
    logic [TIMER_BITS-1:0] r_wait, n_wait;
    logic                  r_scl, n_scl;
    logic                  r_sda, n_sda;
    logic                  r_ack, n_ack;
    logic                  r_ack_choice, n_ack_choice;
    logic [BYTE_BITS-1:0]  r_read, n_read;

    // Result register
    logic                  r_ov;
    logic                  r_o_scl, r_o_sda, r_o_busy, r_o_done, r_o_ack, r_o_rej;
    logic [BYTE_BITS-1:0]  r_o_rd;

    logic                  accept;
    logic                  elapsed;
    logic                  cur_recv;
    logic                  next_recv;
    logic                  do_begin;
    logic                  done;
    logic                  rej;

    // Take a new beat whenever the result register is empty or draining.
    assign i_cmd.ready = !r_ov || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    // A timed wait ends on its last tick; zero counts as one.
    assign elapsed  = (r_wait <= TIMER_BITS'(1));
    // Receiving: data bits of a read, or the ack bit of a write.
    assign cur_recv = (r_active == CMD_WRITE) == (r_bit_count == BIT_CNT_W'(BYTE_BITS));

    always_comb begin
        n_phase      = r_phase;
        n_active     = r_active;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_wait       = r_wait;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_ack        = r_ack;
        n_ack_choice = r_ack_choice;
        n_read       = r_read;
        done         = 1'b0;
        rej          = 1'b0;
        do_begin     = 1'b0;
        next_recv    = 1'b0;

        if (i_cmd.cmd == CMD_TICK) begin
            case (r_phase)
                PH_IDLE: begin
                    // Idle tick: nothing moves.
                end
                PH_ST_DLY: begin
                    if (elapsed) begin
                        n_scl   = 1'b1;
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end else begin
                        n_wait = r_wait - TIMER_BITS'(1);
                    end
                end
                PH_RS_REL: begin
                    if (elapsed) begin
                        n_scl   = 1'b0;
                        n_phase = PH_RS_STR;
                    end else begin
                        n_wait = r_wait - TIMER_BITS'(1);
                    end
                end
                PH_RS_STR: begin
                    if (i_cmd.scl_in) begin
                        n_phase = PH_RS_DLY;
                        n_wait  = TIMER_BITS'(r_half);
                    end
                end
                PH_RS_DLY: begin
                    if (elapsed) begin
                        n_sda   = 1'b1;
                        n_phase = PH_ST_DLY;
                        n_wait  = TIMER_BITS'(r_half);
                    end else begin
                        n_wait = r_wait - TIMER_BITS'(1);
                    end
                end
                PH_SP_PRE: begin
                    if (elapsed) begin
                        n_sda   = 1'b1;
                        n_phase = PH_SP_DLY1;
                        n_wait  = TIMER_BITS'(r_half);
                    end else begin
                        n_wait = r_wait - TIMER_BITS'(1);
                    end
                end
                PH_SP_DLY1: begin
                    if (elapsed) begin
                        n_scl   = 1'b0;
                        n_phase = PH_SP_STR;
                    end else begin
                        n_wait = r_wait - TIMER_BITS'(1);
                    end
                end
                PH_SP_STR: begin
                    if (i_cmd.scl_in) begin
                        n_phase = PH_SP_DLY2;
                        n_wait  = TIMER_BITS'(r_half);
                    end
                end
                PH_SP_DLY2: begin
                    if (elapsed) begin
                        n_sda   = 1'b0;
                        n_phase = PH_SP_POST;
                        n_wait  = TIMER_BITS'(r_stop_post);
                    end else begin
                        n_wait = r_wait - TIMER_BITS'(1);
                    end
                end
                PH_SP_POST: begin
                    if (elapsed) begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end else begin
                        n_wait = r_wait - TIMER_BITS'(1);
                    end
                end
                PH_BIT_SETUP: begin
                    if (elapsed) begin
                        n_scl   = 1'b0;
                        n_phase = PH_BIT_STR;
                    end else begin
                        n_wait = r_wait - TIMER_BITS'(1);
                    end
                end
                PH_BIT_STR: begin
                    // Hold here while the slave stretches SCL.
                    if (i_cmd.scl_in) begin
                        if (cur_recv) begin
                            if (r_active == CMD_WRITE) begin
                                n_ack = !i_cmd.sda_in;
                            end else begin
                                n_shift = {r_shift[BYTE_BITS-2:0], i_cmd.sda_in};
                            end
                        end
                        n_phase = PH_BIT_HOLD;
                        n_wait  = TIMER_BITS'(r_half);
                    end
                end
                PH_BIT_HOLD: begin
                    if (elapsed) begin
                        n_scl       = 1'b1;
                        n_sda       = 1'b0;
                        n_bit_count = r_bit_count + BIT_CNT_W'(1);
                        if (n_bit_count > BIT_CNT_W'(BYTE_BITS)) begin
                            if (r_active == CMD_READ) begin
                                n_read = r_shift;
                            end
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end else begin
                            do_begin = 1'b1;
                        end
                    end else begin
                        n_wait = r_wait - TIMER_BITS'(1);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end else if (r_phase != PH_IDLE) begin
            rej = 1'b1;
        end else begin
            case (i_cmd.cmd)
                CMD_START: begin
                    n_active = i_cmd.cmd;
                    n_sda    = 1'b1;
                    n_phase  = PH_ST_DLY;
                    n_wait   = TIMER_BITS'(r_half);
                end
                CMD_RESTART: begin
                    n_active = i_cmd.cmd;
                    n_sda    = 1'b0;
                    n_phase  = PH_RS_REL;
                    n_wait   = TIMER_BITS'(r_half);
                end
                CMD_STOP: begin
                    n_active = i_cmd.cmd;
                    n_phase  = PH_SP_PRE;
                    n_wait   = TIMER_BITS'(r_stop_pre);
                end
                CMD_WRITE: begin
                    n_active    = i_cmd.cmd;
                    n_bit_count = '0;
                    n_shift     = i_cmd.wr_data;
                    do_begin    = 1'b1;
                end
                CMD_READ: begin
                    n_active     = i_cmd.cmd;
                    n_bit_count  = '0;
                    n_shift      = '0;
                    n_ack_choice = i_cmd.send_ack;
                    do_begin     = 1'b1;
                end
                CMD_PARK: begin
                    n_active = i_cmd.cmd;
                    n_scl    = 1'b1;
                    n_sda    = 1'b1;
                    done     = 1'b1;
                end
                default: begin
                    // Unknown code while idle: drop it silently.
                end
            endcase
        end

        // Set up the next bit: release SDA to receive, else drive data or ack.
        if (do_begin) begin
            next_recv = (n_active == CMD_WRITE) == (n_bit_count == BIT_CNT_W'(BYTE_BITS));
            if (next_recv) begin
                n_sda = 1'b0;
            end else if (n_active == CMD_WRITE) begin
                n_sda   = !n_shift[BYTE_BITS-1];
                n_shift = {n_shift[BYTE_BITS-2:0], 1'b0};
            end else begin
                n_sda = n_ack_choice;
            end
            n_phase = PH_BIT_SETUP;
            n_wait  = TIMER_BITS'(r_half);
        end
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= HALF_BIT_RST;
            r_stop_pre  <= STOP_PRE_RST;
            r_stop_post <= STOP_POST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HALF_BIT:  r_half      <= i_cfg_data;
                REG_STOP_PRE:  r_stop_pre  <= i_cfg_data;
                REG_STOP_POST: r_stop_post <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer state: advance on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_active     <= '0;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_wait       <= '0;
            r_scl        <= 1'b0;
            r_sda        <= 1'b0;
            r_ack        <= 1'b0;
            r_ack_choice <= 1'b0;
            r_read       <= '0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_active     <= n_active;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_wait       <= n_wait;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_ack        <= n_ack;
            r_ack_choice <= n_ack_choice;
            r_read       <= n_read;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (accept) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    // Result payload: load with the state it leaves behind.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_o_scl  <= n_scl;
            r_o_sda  <= n_sda;
            r_o_busy <= (n_phase != PH_IDLE);
            r_o_done <= done;
            r_o_rd   <= n_read;
            r_o_ack  <= n_ack;
            r_o_rej  <= rej;
        end
    end

    assign o_res.valid    = r_ov;
    assign o_res.scl_low  = r_o_scl;
    assign o_res.sda_low  = r_o_sda;
    assign o_res.busy_res = r_o_busy;
    assign o_res.done_res = r_o_done;
    assign o_res.rd_data  = r_o_rd;
    assign o_res.ack_seen = r_o_ack;
    assign o_res.rejected = r_o_rej;

    // A finished command leaves the sequencer idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_done |-> !r_o_busy)
        else $error("done reported while still busy");

    // A rejected command never disturbs a sequence in progress.
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_rej |-> r_o_busy && !r_o_done)
        else $error("rejected beat ended the sequence");

    // Reported busy matches the phase register after the beat.
    a_busy_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_o_busy == (r_phase != PH_IDLE))
        else $error("busy flag disagrees with phase");

    // Bit counter never runs more than one past the ack bit.
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= BIT_CNT_W'(BYTE_BITS + 1))
        else $error("bit counter out of range");

    // Nothing but a tick may move a busy sequencer.
    a_cmd_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (r_phase != PH_IDLE) && (i_cmd.cmd != CMD_TICK) |=> $stable(r_phase))
        else $error("command changed phase while busy");

endmodule
